// ===== src/vtp_pkg.sv =====
// ----------------------------------------------------------------------------
// vtp_pkg: shared constants, types and functions of the vertex transform
// Matrix register layout, datapath widths and the per-bit divider step.
// ----------------------------------------------------------------------------
package vtp_pkg;

  // Screen size; the width scales both axes.
  localparam int unsigned SCREEN_W = 640;
  localparam int unsigned SCREEN_H = 480;

  // Configuration port
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_W     = 64;

  // Register indexes; row 3 only feeds w, which reaches no output.
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
  localparam int unsigned NUM_ROWS   = 3;
  localparam int unsigned NUM_STORED = 2 * NUM_ROWS;
  localparam int unsigned NUM_COLS   = 4;

  localparam logic [CFG_W-1:0] MAT_RST [NUM_STORED] = '{
    64'h0000_0001_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  // Datapath widths
  localparam int unsigned CW      = 32;           // coefficient / input
  localparam int unsigned PRW     = 2 * CW;       // one product
  localparam int unsigned ACC_W   = PRW + 2;      // sum of four products
  localparam int unsigned FRAC    = 16;
  localparam int unsigned VW      = ACC_W - FRAC; // view coordinate
  localparam int unsigned SCL_W   = 16;           // signed screen scale
  localparam int unsigned PW      = VW + SCL_W;   // scaled coordinate
  localparam int unsigned MAG_W   = PW - 1;       // |a - b|
  localparam int unsigned DEN_W   = VW + 1;       // 2 * |vz|
  localparam int unsigned QB      = 17;           // quotient bits kept
  localparam int unsigned REM_W   = DEN_W + QB;   // partial remainder
  localparam int unsigned SW      = 16;           // screen coordinate
  localparam int unsigned DW      = 32;           // depth

  localparam logic signed [SCL_W-1:0] SCALE_W     = SCL_W'(SCREEN_W);
  localparam logic signed [SCL_W-1:0] SCALE_W_NEG = -SCALE_W;
  localparam logic signed [SCL_W-1:0] SCALE_H     = SCL_W'(SCREEN_H);

  localparam logic [QB-1:0] Q_POS_MAX = QB'(32767);
  localparam logic [QB-1:0] Q_NEG_MAX = QB'(32768);
  localparam logic [SW-1:0] SX_MAX    = 16'h7fff;
  localparam logic [SW-1:0] SX_MIN    = 16'h8000;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QB-1:0]    quot;
    logic             neg;
    logic             ovf;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        lx;
    div_lane_t        ly;
    logic [DEN_W-1:0] den;
    logic [DW-1:0]    depth;
    logic             zero;
  } div_stage_t;

  typedef struct packed {
    logic [SW-1:0] sx;
    logic [SW-1:0] sy;
    logic [DW-1:0] depth;
    logic          zero;
  } result_t;

  // One restoring step: try den << b against the partial remainder.
  function automatic div_lane_t lane_step(div_lane_t l, logic [DEN_W-1:0] den,
                                          int unsigned b);
    logic [REM_W-1:0] trial;
    div_lane_t        r;
    trial = REM_W'(den) << b;
    r     = l;
    if (l.rem >= trial) begin
      r.rem  = l.rem - trial;
      r.quot = {l.quot[QB-2:0], 1'b1};
    end else begin
      r.quot = {l.quot[QB-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_stage_t div_stage(div_stage_t s, int unsigned b);
    div_stage_t r;
    r    = s;
    r.lx = lane_step(s.lx, s.den, b);
    r.ly = lane_step(s.ly, s.den, b);
    return r;
  endfunction

  // Apply the sign and clamp to 16-bit signed.
  function automatic logic [SW-1:0] lane_sat(div_lane_t l);
    logic [QB-1:0] nq;
    nq = -l.quot;
    if (!l.neg) begin
      return (l.ovf || l.quot > Q_POS_MAX) ? SX_MAX : l.quot[SW-1:0];
    end
    return (l.ovf || l.quot > Q_NEG_MAX) ? SX_MIN : nq[SW-1:0];
  endfunction

endpackage

// ===== src/vertex_transform_project.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_project: 4x4 vertex transform with perspective projection
// Three matrix rows in 32x32 multipliers, then a one-bit-per-stage divider.
// ----------------------------------------------------------------------------
// Throughput: one vertex per cycle while the skid entry is empty, set by the
// fully pipelined multiplier and 17-stage restoring divider; a two-entry
// output buffer absorbs stalls.
// Reset: the matrix returns to its reset values and all stages empty.
module vertex_transform_project
  import vtp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [CW-1:0] in_x_i,
  input  logic signed [CW-1:0] in_y_i,
  input  logic signed [CW-1:0] in_z_i,
  input  logic signed [CW-1:0] in_w_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [SW-1:0] screen_x_o,
  output logic signed [SW-1:0] screen_y_o,
  output logic signed [DW-1:0] depth_o,
  output logic                 zero_depth_o
);

  localparam int unsigned NS = 5 + QB;  // pipeline stages before the output

  logic [CFG_W-1:0] mat_q [NUM_STORED];
  logic [NS-1:0]    v_q;
  logic             en;

  // Matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STORED; i++) mat_q[i] <= MAT_RST[i];
    end else if (cfg_we_i) begin
      for (int i = 0; i < NUM_STORED; i++) begin
        if (cfg_idx_i == CFG_IDX_W'(i)) mat_q[i] <= cfg_data_i;
      end
    end
  end

  // Stage 0: products
  logic signed [CW-1:0]  vec [NUM_COLS];
  logic signed [PRW-1:0] prod_d [NUM_ROWS][NUM_COLS];
  logic signed [PRW-1:0] prod_q [NUM_ROWS][NUM_COLS];

  assign vec[0] = in_x_i;
  assign vec[1] = in_y_i;
  assign vec[2] = in_z_i;
  assign vec[3] = in_w_i;

  always_comb begin
    logic signed [CW-1:0] c;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int k = 0; k < NUM_COLS; k++) begin
        c = (k % 2 == 1) ? mat_q[2*r + k/2][CFG_W-1:CW] : mat_q[2*r + k/2][CW-1:0];
        prod_d[r][k] = c * vec[k];
      end
    end
  end

  // Stage 1: row sums floored to Q34.16
  logic signed [VW-1:0] dot_d [NUM_ROWS];
  logic signed [VW-1:0] dot_q [NUM_ROWS];

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    for (int r = 0; r < NUM_ROWS; r++) begin
      acc = ACC_W'(prod_q[r][0]) + ACC_W'(prod_q[r][1])
          + ACC_W'(prod_q[r][2]) + ACC_W'(prod_q[r][3]);
      dot_d[r] = acc[ACC_W-1:FRAC];
    end
  end

  // Stage 2: scale by the screen size, depth clamp, divisor
  localparam logic signed [VW-1:0] DEPTH_MAX = {{(VW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [VW-1:0] DEPTH_MIN = {{(VW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic signed [PW-1:0] ax_q, bx_q, ay_q, by_q;
  logic [DEN_W-1:0]     den2_q;
  logic [DW-1:0]        depth2_q;
  logic                 zero2_q, zneg2_q;
  logic signed [VW-1:0] vz;
  logic [VW-1:0]        absz;

  assign vz   = dot_q[2];
  assign absz = vz[VW-1] ? VW'(-vz) : VW'(vz);

  // Stage 3: difference magnitude and sign
  logic [MAG_W-1:0]     magx_q, magy_q;
  logic                 negx_q, negy_q;
  logic [DEN_W-1:0]     den3_q;
  logic [DW-1:0]        depth3_q;
  logic                 zero3_q;
  logic signed [PW-1:0] dx1, dx2, dy1, dy2;

  assign dx1 = ax_q - bx_q;
  assign dx2 = bx_q - ax_q;
  assign dy1 = ay_q - by_q;
  assign dy2 = by_q - ay_q;

  // Stage 4 and the divider
  div_stage_t div_q [QB+1];
  div_stage_t s4_d;
  logic [REM_W-1:0] den_top;

  assign den_top = REM_W'(den3_q) << QB;

  always_comb begin
    s4_d          = '0;
    s4_d.lx.rem   = REM_W'(magx_q);
    s4_d.lx.neg   = negx_q;
    s4_d.lx.ovf   = REM_W'(magx_q) >= den_top;
    s4_d.ly.rem   = REM_W'(magy_q);
    s4_d.ly.neg   = negy_q;
    s4_d.ly.ovf   = REM_W'(magy_q) >= den_top;
    s4_d.den      = den3_q;
    s4_d.depth    = depth3_q;
    s4_d.zero     = zero3_q;
  end

  // Datapath; everything moves together while the output buffer has room
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      dot_q  <= dot_d;

      ax_q     <= vz * SCALE_W;
      bx_q     <= dot_q[0] * SCALE_W_NEG;
      ay_q     <= vz * SCALE_H;
      by_q     <= dot_q[1] * SCALE_W;
      den2_q   <= {absz, 1'b0};
      zero2_q  <= (vz == '0);
      zneg2_q  <= vz[VW-1];
      depth2_q <= (vz > DEPTH_MAX) ? DW'(DEPTH_MAX) :
                  (vz < DEPTH_MIN) ? DW'(DEPTH_MIN) : vz[DW-1:0];

      magx_q   <= (ax_q >= bx_q) ? dx1[MAG_W-1:0] : dx2[MAG_W-1:0];
      negx_q   <= (ax_q < bx_q) ^ zneg2_q;
      magy_q   <= (ay_q >= by_q) ? dy1[MAG_W-1:0] : dy2[MAG_W-1:0];
      negy_q   <= (ay_q < by_q) ^ zneg2_q;
      den3_q   <= den2_q;
      depth3_q <= depth2_q;
      zero3_q  <= zero2_q;

      div_q[0] <= s4_d;
      for (int i = 0; i < QB; i++) div_q[i+1] <= div_stage(div_q[i], QB - 1 - i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // Final clamp
  result_t res_d;

  always_comb begin
    res_d.depth = div_q[QB].depth;
    res_d.zero  = div_q[QB].zero;
    res_d.sx    = div_q[QB].zero ? '0 : lane_sat(div_q[QB].lx);
    res_d.sy    = div_q[QB].zero ? '0 : lane_sat(div_q[QB].ly);
  end

  // Output register plus skid entry
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    out_free;

  assign en       = !skid_valid_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || v_q[NS-1];
      skid_valid_q <= 1'b0;
    end else if (v_q[NS-1] && en) begin
      // output held: park the arriving result
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (v_q[NS-1] && en) begin
      skid_q <= res_d;
    end
  end

  assign in_ready_o   = en;
  assign out_valid_o  = out_valid_q;
  assign screen_x_o   = out_q.sx;
  assign screen_y_o   = out_q.sy;
  assign depth_o      = out_q.depth;
  assign zero_depth_o = out_q.zero;

endmodule

// ===== src/vtp_checker.sv =====
// ----------------------------------------------------------------------------
// vtp_checker: port-level checks for the vertex transform
// Output hold under stall, buffer backpressure and zero-depth consistency.
// ----------------------------------------------------------------------------
module vtp_checker
  import vtp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic signed [SW-1:0] screen_x_o,
  input logic signed [SW-1:0] screen_y_o,
  input logic signed [DW-1:0] depth_o,
  input logic                 zero_depth_o
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(screen_x_o)
      && $stable(screen_y_o) && $stable(depth_o) && $stable(zero_depth_o))
    else $error("stalled result changed");

  // Input backpressure only comes from a full output buffer.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // The depth clamp keeps a nonzero depth nonzero, so zero depth and the flag agree.
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((depth_o == '0) == zero_depth_o))
    else $error("zero_depth disagrees with depth");

  a_zero_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_depth_o |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("nonzero screen coordinate at zero depth");

  // A stall of the output with a full buffer keeps the input blocked.
  a_block_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o)
    else $error("input released while output still stalled");

endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .screen_x_o   (screen_x_o),
  .screen_y_o   (screen_y_o),
  .depth_o      (depth_o),
  .zero_depth_o (zero_depth_o)
);
